/* src/fdcl_pkg.sv */
// ----------------------------------------------------------------------------
// fdcl_pkg
// Shared widths, reset values and types for the frame difference change
// locator.
// ----------------------------------------------------------------------------
package fdcl_pkg;

   // fixed field widths
   localparam int PIX_BITS = 8;

   // defaults for the top level parameters
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COUNT_BITS_DEFAULT = 24;

   // threshold after reset
   localparam logic [PIX_BITS-1:0] THRESH_RESET = 8'd15;

   // control handed from the detect stage to the statistics stage
   typedef struct packed {
      logic valid;
      logic hit;
      logic frame_end;
   } det_ctrl_type;

endpackage

/* src/fdcl_req_if.sv */
// ----------------------------------------------------------------------------
// fdcl_req_if
// Input pixel beat channel: reference and current pixel with coordinates.
// ----------------------------------------------------------------------------
interface fdcl_req_if
   import fdcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [PIX_BITS-1:0]   reference_pixel;
   logic [PIX_BITS-1:0]   current_pixel;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic                  frame_end;

   modport source (
      output valid, reference_pixel, current_pixel, pos_x, pos_y, frame_end,
      input  ready
   );

   modport sink (
      input  valid, reference_pixel, current_pixel, pos_x, pos_y, frame_end,
      output ready
   );
endinterface

/* src/fdcl_rsp_if.sv */
// ----------------------------------------------------------------------------
// fdcl_rsp_if
// Result beat channel: mask bit and, on frame end, the frame statistics.
// ----------------------------------------------------------------------------
interface fdcl_rsp_if
   import fdcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic                         changed;
   logic                         stats_valid;
   logic signed [COORD_BITS:0]   first_x;
   logic signed [COORD_BITS:0]   first_y;
   logic signed [COORD_BITS:0]   last_x;
   logic signed [COORD_BITS:0]   last_y;
   logic [COUNT_BITS-1:0]        changed_count;
   logic [COUNT_BITS-1:0]        unchanged_count;

   modport source (
      output valid, changed, stats_valid, first_x, first_y, last_x, last_y,
             changed_count, unchanged_count,
      input  ready
   );

   modport sink (
      input  valid, changed, stats_valid, first_x, first_y, last_x, last_y,
             changed_count, unchanged_count,
      output ready
   );
endinterface

/* src/fdcl_detect.sv */
// ----------------------------------------------------------------------------
// fdcl_detect
// Input register stage and the clamped difference compare against the
// threshold.
// ----------------------------------------------------------------------------
module fdcl_detect
   import fdcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   fdcl_req_if.sink              req_bus,
   input  logic [PIX_BITS-1:0]   threshold,
   input  logic                  advance,
   output det_ctrl_type          det_ctrl,
   output logic [COORD_BITS-1:0] det_x,
   output logic [COORD_BITS-1:0] det_y
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [PIX_BITS-1:0]   ref_ff;
   logic [PIX_BITS-1:0]   cur_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic                  end_ff;
   logic                  accept;
   logic [PIX_BITS-1:0]   diff;

   // stage frees up when empty or when its beat moves on
   assign req_bus.ready = !valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         ref_ff <= req_bus.reference_pixel;
         cur_ff <= req_bus.current_pixel;
         x_ff   <= req_bus.pos_x;
         y_ff   <= req_bus.pos_y;
         end_ff <= req_bus.frame_end;
      end
   end

   // reference minus current, clamped at zero
   assign diff = (ref_ff > cur_ff) ? (ref_ff - cur_ff) : '0;

   assign det_ctrl.valid     = valid_ff;
   assign det_ctrl.hit       = diff > threshold;
   assign det_ctrl.frame_end = end_ff;
   assign det_x              = x_ff;
   assign det_y              = y_ff;

endmodule

/* src/fdcl_stats.sv */
// ----------------------------------------------------------------------------
// fdcl_stats
// Per-frame first/last changed position and saturating counts, plus the
// result register.
// ----------------------------------------------------------------------------
module fdcl_stats
   import fdcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  det_ctrl_type          det_ctrl,
   input  logic [COORD_BITS-1:0] det_x,
   input  logic [COORD_BITS-1:0] det_y,
   output logic                  advance,
   fdcl_rsp_if.source            rsp_bus
);

   localparam int OUT_BITS = COORD_BITS + 1;
   localparam logic [OUT_BITS-1:0]   POS_NONE  = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // frame statistics
   logic                  any_ff, any_in;
   logic [OUT_BITS-1:0]   first_col_ff, first_col_in;
   logic [OUT_BITS-1:0]   first_row_ff, first_row_in;
   logic [OUT_BITS-1:0]   last_col_ff, last_col_in;
   logic [OUT_BITS-1:0]   last_row_ff, last_row_in;
   logic [COUNT_BITS-1:0] white_ff, white_in;
   logic [COUNT_BITS-1:0] black_ff, black_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  changed_ff;
   logic                  stats_valid_ff;
   logic [OUT_BITS-1:0]   first_x_ff, first_y_ff, last_x_ff, last_y_ff;
   logic [COUNT_BITS-1:0] changed_count_ff, unchanged_count_ff;

   logic                  take;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign take    = advance && det_ctrl.valid;

   // statistics after this pixel
   always_comb begin
      any_in       = any_ff;
      first_col_in = first_col_ff;
      first_row_in = first_row_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      white_in     = white_ff;
      black_in     = black_ff;
      if (det_ctrl.hit) begin
         if (!any_ff) begin
            any_in       = 1'b1;
            first_col_in = {1'b0, det_x};
            first_row_in = {1'b0, det_y};
         end
         last_col_in = {1'b0, det_x};
         last_row_in = {1'b0, det_y};
         if (white_ff != COUNT_MAX) begin
            white_in = white_ff + COUNT_BITS'(1);
         end
      end else begin
         if (black_ff != COUNT_MAX) begin
            black_in = black_ff + COUNT_BITS'(1);
         end
      end
   end

   // statistics registers, cleared after the frame's last pixel
   always_ff @(posedge clock) begin
      if (reset || (take && det_ctrl.frame_end)) begin
         any_ff       <= 1'b0;
         first_col_ff <= POS_NONE;
         first_row_ff <= POS_NONE;
         last_col_ff  <= POS_NONE;
         last_row_ff  <= POS_NONE;
         white_ff     <= '0;
         black_ff     <= '0;
      end else if (take) begin
         any_ff       <= any_in;
         first_col_ff <= first_col_in;
         first_row_ff <= first_row_in;
         last_col_ff  <= last_col_in;
         last_row_ff  <= last_row_in;
         white_ff     <= white_in;
         black_ff     <= black_in;
      end
   end

   // result register, statistics shown only on frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= det_ctrl.valid;
      end
      if (take) begin
         changed_ff     <= det_ctrl.hit;
         stats_valid_ff <= det_ctrl.frame_end;
         if (det_ctrl.frame_end) begin
            first_x_ff         <= first_col_in;
            first_y_ff         <= first_row_in;
            last_x_ff          <= last_col_in;
            last_y_ff          <= last_row_in;
            changed_count_ff   <= white_in;
            unchanged_count_ff <= black_in;
         end else begin
            first_x_ff         <= '0;
            first_y_ff         <= '0;
            last_x_ff          <= '0;
            last_y_ff          <= '0;
            changed_count_ff   <= '0;
            unchanged_count_ff <= '0;
         end
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.changed         = changed_ff;
   assign rsp_bus.stats_valid     = stats_valid_ff;
   assign rsp_bus.first_x         = signed'(first_x_ff);
   assign rsp_bus.first_y         = signed'(first_y_ff);
   assign rsp_bus.last_x          = signed'(last_x_ff);
   assign rsp_bus.last_y          = signed'(last_y_ff);
   assign rsp_bus.changed_count   = changed_count_ff;
   assign rsp_bus.unchanged_count = unchanged_count_ff;

endmodule

/* src/frame_difference_change_locator_core.sv */
// ----------------------------------------------------------------------------
// frame_difference_change_locator_core
// Frame difference change detector with per-frame change statistics.
// ----------------------------------------------------------------------------
// One pixel beat is taken per clock and gives exactly one result beat
// through an input register, then the difference compare and the
// statistics update feeding the result register. The throughput of one
// beat per clock holds as long as the result side takes beats; a stalled
// result holds the input register, which still frees up in the same cycle
// the result is taken. A pixel is changed when reference minus current,
// clamped at zero, is above the threshold (reset value 15). On the beat
// flagged frame_end the result carries first/last changed position (-1 if
// none) and the saturating changed/unchanged counts, including that pixel;
// all statistics fields read zero on other beats. The block does not enforce
// it: write the threshold via csr_write_enable/csr_write_data only while idle.
// ----------------------------------------------------------------------------
module frame_difference_change_locator_core
   import fdcl_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [PIX_BITS-1:0] csr_write_data,
   fdcl_req_if.sink            req_bus,
   fdcl_rsp_if.source          rsp_bus
);

   logic [PIX_BITS-1:0]   threshold_ff;
   logic                  advance;
   det_ctrl_type          det_ctrl;
   logic [COORD_BITS-1:0] det_x;
   logic [COORD_BITS-1:0] det_y;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   fdcl_detect #(
      .COORD_BITS (COORD_BITS)
   ) u_detect (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .threshold (threshold_ff),
      .advance   (advance),
      .det_ctrl  (det_ctrl),
      .det_x     (det_x),
      .det_y     (det_y)
   );

   fdcl_stats #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .det_ctrl (det_ctrl),
      .det_x    (det_x),
      .det_y    (det_y),
      .advance  (advance),
      .rsp_bus  (rsp_bus)
   );

endmodule

/* test/frame_difference_change_locator_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_difference_change_locator_core_tb
// Self-checking bench for the frame difference change locator. A directed
// table hits the pixel and coordinate extremes, the threshold edge, the
// zero clamp and single-pixel frames. Random frames follow over several
// threshold settings. Every result beat is checked field by field against
// its typed table row or an in-bench predictor, with random idling on both
// channels and long result stalls that back the block up.
// ----------------------------------------------------------------------------
module frame_difference_change_locator_core_tb;
   import fdcl_pkg::*;

   // narrowest supported counter width
   localparam int COORD_W        = COORD_BITS_DEFAULT;
   localparam int COUNT_W        = 16;
   localparam int PHASE_BEATS    = 155;
   localparam int NUM_PHASES     = 7;
   localparam int CALM_PHASE     = 3;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS  = 12;
   localparam int PRINT_LIMIT    = 30;
   localparam int RANDOM_THRESH  = -1;

   localparam logic signed [COORD_W:0] NO_POS = -1;

   typedef struct packed {
      logic [PIX_BITS-1:0] ref_pix;
      logic [PIX_BITS-1:0] cur_pix;
      logic [COORD_W-1:0]  col;
      logic [COORD_W-1:0]  row;
      logic                eof;
   } pixel_beat_type;

   typedef struct packed {
      logic                      changed;
      logic                      stats_valid;
      logic signed [COORD_W:0]   first_x;
      logic signed [COORD_W:0]   first_y;
      logic signed [COORD_W:0]   last_x;
      logic signed [COORD_W:0]   last_y;
      logic [COUNT_W-1:0]        changed_count;
      logic [COUNT_W-1:0]        unchanged_count;
   } mask_stats_type;

   typedef struct packed {
      pixel_beat_type beat;
      logic           typed;
      mask_stats_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [PIX_BITS-1:0] csr_write_data;

   fdcl_req_if #(.COORD_BITS(COORD_W)) req_bus ();
   fdcl_rsp_if #(.COORD_BITS(COORD_W), .COUNT_BITS(COUNT_W)) rsp_bus ();

   frame_difference_change_locator_core #(
      .COORD_BITS(COORD_W),
      .COUNT_BITS(COUNT_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   // predictor state: threshold plus running frame statistics
   logic [PIX_BITS-1:0]     threshold_q;
   logic                    hit_seen;
   logic signed [COORD_W:0] first_col, first_row, last_col, last_row;
   logic [COUNT_W-1:0]      hit_total, miss_total;

   mask_stats_type expected_q[$];

   int  mismatches;
   int  results_checked;
   int  beats_sent;
   int  frames_sent;
   int  thresholds_used;
   bit  steady;

   // directed table: typed rows carry the expectation, the rest use the predictor
   directed_row_type directed_plan [DIRECTED_ROWS] = '{
      // largest positive difference at the origin
      '{'{8'd255, 8'd0, 12'd0, 12'd0, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 16'd0, 16'd0}},
      // negative difference clamps to zero, far corner
      '{'{8'd0, 8'd255, 12'd4095, 12'd4095, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 16'd0, 16'd0}},
      // difference equal to threshold is not a change
      '{'{8'd15, 8'd0, 12'd1, 12'd2, 1'b0}, 1'b1,
        '{1'b0, 1'b0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 16'd0, 16'd0}},
      // one above threshold closes the frame
      '{'{8'd16, 8'd0, 12'd4095, 12'd0, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 13'sd0, 13'sd0, 13'sd4095, 13'sd0, 16'd2, 16'd2}},
      // one-pixel frame with no change
      '{'{8'd0, 8'd0, 12'd7, 12'd9, 1'b1}, 1'b1,
        '{1'b0, 1'b1, NO_POS, NO_POS, NO_POS, NO_POS, 16'd0, 16'd1}},
      // one-pixel frame with a change
      '{'{8'd200, 8'd100, 12'd4095, 12'd4095, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 13'sd4095, 13'sd4095, 13'sd4095, 13'sd4095, 16'd1, 16'd0}},
      '{'{8'd128, 8'd127, 12'hAAA, 12'h555, 1'b0}, 1'b0, '0},
      '{'{8'd31, 8'd15, 12'h555, 12'hAAA, 1'b0}, 1'b0, '0},
      '{'{8'd100, 8'd116, 12'hFFF, 12'h000, 1'b0}, 1'b0, '0},
      '{'{8'd255, 8'd240, 12'h800, 12'h001, 1'b0}, 1'b0, '0},
      '{'{8'd254, 8'd0, 12'h001, 12'h800, 1'b0}, 1'b0, '0},
      '{'{8'd0, 8'd0, 12'h7FF, 12'hFFE, 1'b1}, 1'b0, '0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_frame_stats();
      hit_seen   = 1'b0;
      first_col  = NO_POS;
      first_row  = NO_POS;
      last_col   = NO_POS;
      last_row   = NO_POS;
      hit_total  = '0;
      miss_total = '0;
   endfunction

   // mask bit and end-of-frame statistics for one accepted pixel
   function automatic mask_stats_type predict_beat(input pixel_beat_type b);
      mask_stats_type      r;
      logic [PIX_BITS:0]   diff;
      logic                hit;
      diff = (b.ref_pix > b.cur_pix) ? b.ref_pix - b.cur_pix : '0;
      hit  = diff > threshold_q;
      if (hit) begin
         if (!hit_seen) begin
            hit_seen  = 1'b1;
            first_col = {1'b0, b.col};
            first_row = {1'b0, b.row};
         end
         last_col = {1'b0, b.col};
         last_row = {1'b0, b.row};
         if (hit_total != '1) hit_total++;
      end else if (miss_total != '1) begin
         miss_total++;
      end
      r             = '0;
      r.changed     = hit;
      r.stats_valid = b.eof;
      if (b.eof) begin
         r.first_x         = first_col;
         r.first_y         = first_row;
         r.last_x          = last_col;
         r.last_y          = last_row;
         r.changed_count   = hit_total;
         r.unchanged_count = miss_total;
         clear_frame_stats();
      end
      return r;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                   results_checked, name, got, want));
   endtask

   // offer one pixel beat and record its expectation once taken
   task automatic send_pixel(input pixel_beat_type b, input logic typed,
                             input mask_stats_type want);
      int             gap;
      mask_stats_type model;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.reference_pixel <= b.ref_pix;
      req_bus.current_pixel   <= b.cur_pix;
      req_bus.pos_x           <= b.col;
      req_bus.pos_y           <= b.row;
      req_bus.frame_end       <= b.eof;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model = predict_beat(b);
      expected_q.push_back(typed ? want : model);
      beats_sent++;
      if (b.eof) frames_sent++;
   endtask

   // threshold write once every result is back
   task automatic write_threshold(input logic [PIX_BITS-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      threshold_q = value;
      thresholds_used++;
   endtask

   // random frames: background with a changed blob, noise, threshold edges
   task automatic drive_frames(input int budget);
      int          sent, len, width, mode, i, cur, refv, step, blob_lo, blob_hi;
      logic [COORD_W-1:0] x0, y0;
      pixel_beat_type b;
      sent = 0;
      while (sent < budget) begin
         len     = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(1, 24);
         width   = $urandom_range(1, 16);
         x0      = COORD_W'($urandom);
         y0      = COORD_W'($urandom);
         mode    = $urandom_range(0, 3);
         blob_lo = $urandom_range(0, len - 1);
         blob_hi = $urandom_range(blob_lo, len - 1);
         for (i = 0; i < len; i++) begin
            cur = $urandom_range(0, 255);
            case (mode)
               0: begin
                  if (i >= blob_lo && i <= blob_hi) begin
                     step = $urandom_range(1, 40);
                     refv = cur + threshold_q + step;
                  end else if ($urandom_range(0, 1) == 1) begin
                     step = $urandom_range(0, 30);
                     refv = cur - step;
                  end else begin
                     step = $urandom_range(0, threshold_q);
                     refv = cur + step;
                  end
               end
               2: begin
                  step = $urandom_range(0, 2);
                  refv = cur + threshold_q + step - 1;
               end
               default: refv = $urandom_range(0, 255);
            endcase
            if (refv < 0) refv = 0;
            if (refv > 255) refv = 255;
            b.ref_pix = refv[PIX_BITS-1:0];
            b.cur_pix = cur[PIX_BITS-1:0];
            if (mode == 3) begin
               b.col = COORD_W'($urandom);
               b.row = COORD_W'($urandom);
            end else begin
               b.col = x0 + COORD_W'(i % width);
               b.row = y0 + COORD_W'(i / width);
            end
            b.eof = (i == len - 1);
            send_pixel(b, 1'b0, '0);
         end
         sent += len;
      end
   endtask

   // result side: check each beat, random stalls and long hold-offs
   int idle_left;
   int hold_left;
   int holds_left;
   int next_hold_at;

   task automatic check_result();
      mask_stats_type got, want;
      got.changed         = rsp_bus.changed;
      got.stats_valid     = rsp_bus.stats_valid;
      got.first_x         = rsp_bus.first_x;
      got.first_y         = rsp_bus.first_y;
      got.last_x          = rsp_bus.last_x;
      got.last_y          = rsp_bus.last_y;
      got.changed_count   = rsp_bus.changed_count;
      got.unchanged_count = rsp_bus.unchanged_count;
      if (expected_q.size() == 0) begin
         report_mismatch("result beat with nothing expected");
      end else begin
         want = expected_q.pop_front();
         compare_field("changed", got.changed, want.changed);
         compare_field("stats_valid", got.stats_valid, want.stats_valid);
         compare_field("first_x", got.first_x, want.first_x);
         compare_field("first_y", got.first_y, want.first_y);
         compare_field("last_x", got.last_x, want.last_x);
         compare_field("last_y", got.last_y, want.last_y);
         compare_field("changed_count", got.changed_count, want.changed_count);
         compare_field("unchanged_count", got.unchanged_count, want.unchanged_count);
      end
      results_checked++;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      idle_left     = 0;
      hold_left     = 0;
      holds_left    = 2;
      next_hold_at  = 200;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!steady && holds_left > 0 && results_checked >= next_hold_at) begin
            // long back-pressure so the pipeline fills and stalls the input
            holds_left--;
            next_hold_at += 400;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            idle_left = pick_gap();
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   int quiet_cycles;
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_q.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // main sequence
   int          phase_thresh [NUM_PHASES] = '{0, 255, RANDOM_THRESH, 1, 254,
                                              THRESH_RESET, RANDOM_THRESH};
   int          p, i, value;

   initial begin
      reset                   <= 1'b1;
      csr_write_enable        <= 1'b0;
      csr_write_data          <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.reference_pixel <= '0;
      req_bus.current_pixel   <= '0;
      req_bus.pos_x           <= '0;
      req_bus.pos_y           <= '0;
      req_bus.frame_end       <= 1'b0;
      steady          = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      beats_sent      = 0;
      frames_sent     = 0;
      thresholds_used = 1;
      threshold_q     = THRESH_RESET;
      clear_frame_stats();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows at the reset threshold
      for (i = 0; i < DIRECTED_ROWS; i++)
         send_pixel(directed_plan[i].beat, directed_plan[i].typed, directed_plan[i].want);

      for (p = 0; p < NUM_PHASES; p++) begin
         value = (phase_thresh[p] == RANDOM_THRESH) ? $urandom_range(2, 253)
                                                    : phase_thresh[p];
         write_threshold(value[PIX_BITS-1:0]);
         steady = (p == CALM_PHASE);
         drive_frames(PHASE_BEATS);
         steady = 1'b0;
      end

      // drain
      req_bus.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d pixel beats in %0d frames at %0d threshold settings",
               beats_sent, frames_sent, thresholds_used);
      $display("run: %0d result beats compared, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
